>>> rtl/log_log_table_interpolator_unit_assert.svh
// assertion macros for the log-log table interpolator
`ifndef LOG_LOG_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH
`define LOG_LOG_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LLTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LLTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/llti_pkg.sv
// shared types, constants and tables for the log-log table interpolator
package llti_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 512;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = (IDX_W + 1 > 10) ? IDX_W + 1 : 10;
  localparam int KNOT_W      = 96;

  // fixed-point constants
  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;

  // register indexes and function codes
  localparam logic [0:0] REG_ENTRIES_USED = 1'b0;
  localparam logic [0:0] REG_DENSITY      = 1'b1;
  localparam logic       FUNC_LOAD        = 1'b0;
  localparam logic       FUNC_QUERY       = 1'b1;

  typedef struct packed {
    logic               func;
    logic [8:0]         entry_index;
    logic signed [31:0] entry_log_energy;
    logic signed [31:0] entry_log_mu;
    logic signed [31:0] entry_log_mu_en;
    logic [31:0]        query_energy;
  } in_item_t;

  typedef struct packed {
    logic [31:0] mu_over_rho;
    logic [31:0] mu_en_over_rho;
    logic [31:0] mu_linear;
    logic [31:0] mu_en_linear;
    logic        not_interpolated;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ,
    ST_LN_ABS,
    ST_LN_MUL,
    ST_LN_FIN,
    ST_SRCH_INIT,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_RD_HI,
    ST_RD_WAIT,
    ST_CMP,
    ST_LERP_DY,
    ST_LERP_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_LERP_FIN,
    ST_EXP_ABS,
    ST_EXP_MUL,
    ST_EXP_T,
    ST_EXP_STEP,
    ST_EXP_SH,
    ST_DEN_MUL,
    ST_DEN_FIN,
    ST_DONE
  } state_t;

  typedef logic [31:0] exp_tab_t [28];

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    n     = n_in;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (n >= res + bit_v) begin
        n   = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(28-i)) in Q30 for fraction bit i
  function automatic exp_tab_t exp_c_table();
    exp_tab_t    t;
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int i = 27; i >= 0; i--) begin
      c    = isqrt64(c << 30);
      t[i] = c[31:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_C = exp_c_table();

endpackage

>>> rtl/log_log_table_interpolator_unit.sv
// log-log attenuation table: knot store, binary search, interpolation and exp
//
// Input channel (in_valid / in_stall / in_data) carries either a load, which
// writes one knot into the table as it is taken, or a query at an energy.
// A query runs on one shared 32x32 multiplier and a bit-serial divider under a
// sequencer: normalization one bit at a time, 28 squaring steps for log2, ln
// scaling by ln 2, a binary search (9 probes for 512 knots), reads of the
// lower and upper knot, a 32-step division per interpolated value, then an
// exponential and a density product per value. While a query runs, in_stall
// stays high until its result sits in the output register. The result channel
// (out_valid / out_stall / out_data) holds one finished transfer; a new item
// is taken while it waits, and only a second finished query waits for the
// receiver. Loads produce no transfer.
// Configuration: cfg_we writes cfg_data into register cfg_index (entries_used,
// density); the user must write only while idle; the block does not enforce it.
// Reset (rst_n low, synchronous) returns to idle, empties the output register
// and sets entries_used to 1 and density to 1.0; the knot table is not
// cleared and must be loaded before it is queried.
`include "log_log_table_interpolator_unit_assert.svh"

module log_log_table_interpolator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  llti_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output llti_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [23:0]          cfg_data
);

  localparam int IW = llti_pkg::IDX_W;
  localparam int CW = llti_pkg::CNT_W;

  llti_pkg::state_t state_r, state_nxt;

  logic [9:0]  entries_used_r;
  logic [23:0] density_r;

  logic [31:0] x_r, x_nxt;
  logic [4:0]  p_r, p_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [27:0] frac_r, frac_nxt;
  logic        below_r, below_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic        lneg_r, lneg_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic signed [31:0] lx_r, lx_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic signed [31:0] e_lo_r, e_lo_nxt, e_hi_r, e_hi_nxt;
  logic signed [31:0] mu_lo_r, mu_lo_nxt, mue_lo_r, mue_lo_nxt;
  logic signed [31:0] mu_hi_r, mu_hi_nxt, mue_hi_r, mue_hi_nxt;
  logic        inside_r, inside_nxt;
  logic [31:0] d_r, d_nxt, dx_r, dx_nxt;
  logic        sel_r, sel_nxt;
  logic        dneg_r, dneg_nxt;
  logic [31:0] ady_r, ady_nxt;
  logic [31:0] rem_r, rem_nxt, dvd_r, dvd_nxt;
  logic signed [31:0] y_r [2];
  logic signed [31:0] y_nxt [2];
  logic [31:0] emag_r, emag_nxt;
  logic        eneg_r, eneg_nxt;
  logic [9:0]  k_r, k_nxt;
  logic [27:0] f_r, f_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] val_r [2];
  logic [31:0] val_nxt [2];
  logic [31:0] lin_r [2];
  logic [31:0] lin_nxt [2];
  logic        out_valid_r, out_valid_nxt;
  llti_pkg::out_item_t out_data_r, out_data_nxt;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // knot ram ports
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr, ram_raddr;
  logic [llti_pkg::KNOT_W-1:0]  ram_wdata, ram_rdata;

  logic in_xfer;
  logic out_xfer;

  assign in_stall  = (state_r != llti_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign mul_p     = mul_a * mul_b;

  llti_ram #(
    .WIDTH (llti_pkg::KNOT_W),
    .DEPTH (llti_pkg::MAX_ENTRIES)
  ) u_knots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    logic [IW-1:0] span;
    span      = hi_r - lo_r;
    state_nxt = state_r;
    unique case (state_r)
      llti_pkg::ST_IDLE: begin
        if (in_xfer && in_data.func == llti_pkg::FUNC_QUERY) begin
          state_nxt = (in_data.query_energy == '0) ? llti_pkg::ST_SRCH_INIT
                                                   : llti_pkg::ST_NORM;
        end
      end
      llti_pkg::ST_NORM:      if (x_r[31]) state_nxt = llti_pkg::ST_SQ;
      llti_pkg::ST_SQ:        if (cnt_r == 5'd27) state_nxt = llti_pkg::ST_LN_ABS;
      llti_pkg::ST_LN_ABS:    state_nxt = llti_pkg::ST_LN_MUL;
      llti_pkg::ST_LN_MUL:    state_nxt = llti_pkg::ST_LN_FIN;
      llti_pkg::ST_LN_FIN:    state_nxt = llti_pkg::ST_SRCH_INIT;
      llti_pkg::ST_SRCH_INIT: state_nxt = llti_pkg::ST_SRCH;
      llti_pkg::ST_SRCH: begin
        state_nxt = (span > IW'(1)) ? llti_pkg::ST_SRCH_CMP : llti_pkg::ST_RD_HI;
      end
      llti_pkg::ST_SRCH_CMP:  state_nxt = llti_pkg::ST_SRCH;
      llti_pkg::ST_RD_HI:     state_nxt = llti_pkg::ST_RD_WAIT;
      llti_pkg::ST_RD_WAIT:   state_nxt = llti_pkg::ST_CMP;
      llti_pkg::ST_CMP: begin
        state_nxt = (!below_r && lx_r > e_lo_r && lx_r < e_hi_r)
                    ? llti_pkg::ST_LERP_DY : llti_pkg::ST_EXP_ABS;
      end
      llti_pkg::ST_LERP_DY:   state_nxt = llti_pkg::ST_LERP_MUL;
      llti_pkg::ST_LERP_MUL:  state_nxt = llti_pkg::ST_DIV_INIT;
      llti_pkg::ST_DIV_INIT:  state_nxt = llti_pkg::ST_DIV;
      llti_pkg::ST_DIV:       if (cnt_r == 5'd31) state_nxt = llti_pkg::ST_LERP_FIN;
      llti_pkg::ST_LERP_FIN: begin
        state_nxt = sel_r ? llti_pkg::ST_EXP_ABS : llti_pkg::ST_LERP_DY;
      end
      llti_pkg::ST_EXP_ABS:   state_nxt = llti_pkg::ST_EXP_MUL;
      llti_pkg::ST_EXP_MUL:   state_nxt = llti_pkg::ST_EXP_T;
      llti_pkg::ST_EXP_T:     state_nxt = llti_pkg::ST_EXP_STEP;
      llti_pkg::ST_EXP_STEP:  if (cnt_r == 5'd0) state_nxt = llti_pkg::ST_EXP_SH;
      llti_pkg::ST_EXP_SH: begin
        state_nxt = sel_r ? llti_pkg::ST_DEN_MUL : llti_pkg::ST_EXP_ABS;
      end
      llti_pkg::ST_DEN_MUL:   state_nxt = llti_pkg::ST_DEN_FIN;
      llti_pkg::ST_DEN_FIN: begin
        state_nxt = sel_r ? llti_pkg::ST_DONE : llti_pkg::ST_DEN_MUL;
      end
      llti_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = llti_pkg::ST_IDLE;
      end
      default: state_nxt = llti_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [32:0]   s33;
    logic [5:0]    pm;
    logic [33:0]   lval, labs;
    logic [63:0]   full;
    logic [31:0]   lnm;
    logic [IW:0]   sum_idx;
    logic [CW-1:0] eu, n_eff;
    logic signed [31:0] ek;
    logic [32:0]   diff33;
    logic signed [31:0] y1v, y2v;
    logic [32:0]   dy33, ady33, t33, yv33;
    logic [63:0]   num;
    logic [63:0]   tsum;
    logic [35:0]   tm;
    logic [9:0]    kpos;
    logic [10:0]   sh, s;
    logic [5:0]    amt;
    logic [32:0]   rnd, tmp, shd;
    logic [31:0]   v;
    logic [47:0]   dp;

    x_nxt         = x_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    frac_nxt      = frac_r;
    below_nxt     = below_r;
    mag_nxt       = mag_r;
    lneg_nxt      = lneg_r;
    prod_nxt      = prod_r;
    lx_nxt        = lx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    e_lo_nxt      = e_lo_r;
    e_hi_nxt      = e_hi_r;
    mu_lo_nxt     = mu_lo_r;
    mue_lo_nxt    = mue_lo_r;
    mu_hi_nxt     = mu_hi_r;
    mue_hi_nxt    = mue_hi_r;
    inside_nxt    = inside_r;
    d_nxt         = d_r;
    dx_nxt        = dx_r;
    sel_nxt       = sel_r;
    dneg_nxt      = dneg_r;
    ady_nxt       = ady_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    y_nxt         = y_r;
    emag_nxt      = emag_r;
    eneg_nxt      = eneg_r;
    k_nxt         = k_r;
    f_nxt         = f_r;
    r_nxt         = r_r;
    val_nxt       = val_r;
    lin_nxt       = lin_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    mul_a         = x_r;
    mul_b         = x_r;
    ram_we        = 1'b0;
    ram_waddr     = IW'(in_data.entry_index);
    ram_wdata     = {in_data.entry_log_energy, in_data.entry_log_mu,
                     in_data.entry_log_mu_en};
    ram_raddr     = lo_r;
    v             = '0;

    // working values shared by several states
    sum_idx = {1'b0, lo_r} + {1'b0, hi_r};
    eu      = CW'(entries_used_r);
    if (eu == '0) begin
      n_eff = CW'(1);
    end else if (eu > CW'(llti_pkg::MAX_ENTRIES)) begin
      n_eff = CW'(llti_pkg::MAX_ENTRIES);
    end else begin
      n_eff = eu;
    end
    ek   = ram_rdata[95:64];
    y1v  = sel_r ? mue_lo_r : mu_lo_r;
    y2v  = sel_r ? mue_hi_r : mu_hi_r;
    s33  = mul_p[63:31];
    pm   = {1'b0, p_r} - 6'd20;
    lval = {pm, frac_r};
    labs = lval[33] ? (34'd0 - lval) : lval;
    full = prod_r + (mag_r[32] ? {llti_pkg::LN2_Q30, 32'd0} : 64'd0) + (64'd1 << 33);
    lnm  = {2'b00, full[63:34]};
    diff33 = {e_hi_r[31], e_hi_r} - {e_lo_r[31], e_lo_r};
    dy33   = {y2v[31], y2v} - {y1v[31], y1v};
    ady33  = dy33[32] ? (33'd0 - dy33) : dy33;
    num    = prod_r + {33'd0, d_r[31:1]};
    t33    = {rem_r, dvd_r[31]};
    yv33   = dneg_r ? ({y1v[31], y1v} - {1'b0, dvd_r}) : ({y1v[31], y1v} + {1'b0, dvd_r});
    tsum   = prod_r + (64'd1 << 25);
    tm     = tsum[61:26];
    kpos   = {2'b00, tm[35:28]};
    sh     = {k_r[9], k_r} - 11'd14;
    s      = 11'd0 - sh;
    amt    = s[5:0];
    rnd    = 33'd1 << (amt - 6'd1);
    tmp    = {1'b0, r_r} + rnd;
    shd    = tmp >> amt;
    dp     = prod_r[63:16] + {47'd0, prod_r[15]};

    unique case (state_r)
      // loads write the ram at once, queries start the log
      llti_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.func == llti_pkg::FUNC_LOAD) begin
            ram_we = (CW'(in_data.entry_index) < CW'(llti_pkg::MAX_ENTRIES));
          end else begin
            below_nxt = (in_data.query_energy == '0);
            x_nxt     = in_data.query_energy;
            p_nxt     = 5'd31;
          end
        end
      end
      // one bit of normalization per cycle
      llti_pkg::ST_NORM: begin
        cnt_nxt  = 5'd0;
        frac_nxt = '0;
        if (!x_r[31]) begin
          x_nxt = {x_r[30:0], 1'b0};
          p_nxt = p_r - 5'd1;
        end
      end
      // repeated squaring yields one log2 fraction bit per cycle
      llti_pkg::ST_SQ: begin
        if (s33[32]) begin
          x_nxt    = s33[32:1];
          frac_nxt = {frac_r[26:0], 1'b1};
        end else begin
          x_nxt    = s33[31:0];
          frac_nxt = {frac_r[26:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      llti_pkg::ST_LN_ABS: begin
        lneg_nxt = lval[33];
        mag_nxt  = labs[32:0];
      end
      llti_pkg::ST_LN_MUL: begin
        mul_a    = mag_r[31:0];
        mul_b    = llti_pkg::LN2_Q30;
        prod_nxt = mul_p;
      end
      llti_pkg::ST_LN_FIN: begin
        lx_nxt = lneg_r ? (32'sd0 - $signed(lnm)) : $signed(lnm);
      end
      llti_pkg::ST_SRCH_INIT: begin
        lo_nxt = '0;
        hi_nxt = IW'(n_eff - CW'(1));
      end
      // probe the midpoint, or fetch the lower knot when the window closes
      llti_pkg::ST_SRCH: begin
        mid_nxt   = sum_idx[IW:1];
        ram_raddr = (hi_r - lo_r > IW'(1)) ? sum_idx[IW:1] : lo_r;
      end
      llti_pkg::ST_SRCH_CMP: begin
        if (below_r || ek > lx_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r;
        end
      end
      llti_pkg::ST_RD_HI: begin
        ram_raddr  = hi_r;
        e_lo_nxt   = ram_rdata[95:64];
        mu_lo_nxt  = ram_rdata[63:32];
        mue_lo_nxt = ram_rdata[31:0];
      end
      llti_pkg::ST_RD_WAIT: begin
        e_hi_nxt   = ram_rdata[95:64];
        mu_hi_nxt  = ram_rdata[63:32];
        mue_hi_nxt = ram_rdata[31:0];
      end
      // bracket test; outside the bracket the lower knot is used as is
      llti_pkg::ST_CMP: begin
        inside_nxt = !below_r && lx_r > e_lo_r && lx_r < e_hi_r;
        d_nxt      = diff33[31:0];
        dx_nxt     = lx_r - e_lo_r;
        sel_nxt    = 1'b0;
        y_nxt[0]   = mu_lo_r;
        y_nxt[1]   = mue_lo_r;
      end
      llti_pkg::ST_LERP_DY: begin
        dneg_nxt = dy33[32];
        ady_nxt  = ady33[31:0];
      end
      llti_pkg::ST_LERP_MUL: begin
        mul_a    = ady_r;
        mul_b    = dx_r;
        prod_nxt = mul_p;
      end
      llti_pkg::ST_DIV_INIT: begin
        rem_nxt = num[63:32];
        dvd_nxt = num[31:0];
        cnt_nxt = 5'd0;
      end
      // restoring divider, one quotient bit per cycle
      llti_pkg::ST_DIV: begin
        if (t33 >= {1'b0, d_r}) begin
          rem_nxt = 32'(t33 - {1'b0, d_r});
          dvd_nxt = {dvd_r[30:0], 1'b1};
        end else begin
          rem_nxt = t33[31:0];
          dvd_nxt = {dvd_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      llti_pkg::ST_LERP_FIN: begin
        y_nxt[sel_r] = yv33[31:0];
        sel_nxt      = !sel_r;
      end
      llti_pkg::ST_EXP_ABS: begin
        eneg_nxt = y_r[sel_r][31];
        emag_nxt = y_r[sel_r][31] ? (32'd0 - y_r[sel_r]) : y_r[sel_r];
      end
      llti_pkg::ST_EXP_MUL: begin
        mul_a    = emag_r;
        mul_b    = llti_pkg::LOG2E_Q30;
        prod_nxt = mul_p;
      end
      // split log2 into integer part and 28 fraction bits
      llti_pkg::ST_EXP_T: begin
        if (!eneg_r) begin
          k_nxt = kpos;
          f_nxt = tm[27:0];
        end else begin
          k_nxt = 10'd0 - kpos - {9'd0, (tm[27:0] != '0)};
          f_nxt = 28'd0 - tm[27:0];
        end
        r_nxt   = 32'h4000_0000;
        cnt_nxt = 5'd27;
      end
      // one constant factor per fraction bit, top bit first
      llti_pkg::ST_EXP_STEP: begin
        mul_a = r_r;
        mul_b = llti_pkg::EXP_C[cnt_r];
        if (f_r[cnt_r]) begin
          r_nxt = 32'((mul_p + (64'd1 << 29)) >> 30);
        end
        cnt_nxt = cnt_r - 5'd1;
      end
      // scale to Q16.16 with saturation or rounding
      llti_pkg::ST_EXP_SH: begin
        if (!sh[10]) begin
          if (sh >= 11'd2) begin
            v = llti_pkg::SAT32;
          end else if (sh == 11'd1) begin
            v = r_r[31] ? llti_pkg::SAT32 : {r_r[30:0], 1'b0};
          end else begin
            v = r_r;
          end
        end else if (s >= 11'd33) begin
          v = 32'd0;
        end else begin
          v = shd[31:0];
        end
        val_nxt[sel_r] = v;
        sel_nxt        = !sel_r;
      end
      llti_pkg::ST_DEN_MUL: begin
        mul_a    = val_r[sel_r];
        mul_b    = {8'd0, density_r};
        prod_nxt = mul_p;
      end
      llti_pkg::ST_DEN_FIN: begin
        lin_nxt[sel_r] = (dp[47:32] != '0) ? llti_pkg::SAT32 : dp[31:0];
        sel_nxt        = !sel_r;
      end
      // hand the result to the output register once it is free
      llti_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.mu_over_rho      = val_r[0];
          out_data_nxt.mu_en_over_rho   = val_r[1];
          out_data_nxt.mu_linear        = lin_r[0];
          out_data_nxt.mu_en_linear     = lin_r[1];
          out_data_nxt.not_interpolated = !inside_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= llti_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      entries_used_r <= 10'd1;
      density_r      <= 24'd65536;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == llti_pkg::REG_ENTRIES_USED) begin
        entries_used_r <= cfg_data[9:0];
      end
      if (cfg_we && cfg_index == llti_pkg::REG_DENSITY) begin
        density_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    p_r        <= p_nxt;
    cnt_r      <= cnt_nxt;
    frac_r     <= frac_nxt;
    below_r    <= below_nxt;
    mag_r      <= mag_nxt;
    lneg_r     <= lneg_nxt;
    prod_r     <= prod_nxt;
    lx_r       <= lx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    e_lo_r     <= e_lo_nxt;
    e_hi_r     <= e_hi_nxt;
    mu_lo_r    <= mu_lo_nxt;
    mue_lo_r   <= mue_lo_nxt;
    mu_hi_r    <= mu_hi_nxt;
    mue_hi_r   <= mue_hi_nxt;
    inside_r   <= inside_nxt;
    d_r        <= d_nxt;
    dx_r       <= dx_nxt;
    sel_r      <= sel_nxt;
    dneg_r     <= dneg_nxt;
    ady_r      <= ady_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    y_r        <= y_nxt;
    emag_r     <= emag_nxt;
    eneg_r     <= eneg_nxt;
    k_r        <= k_nxt;
    f_r        <= f_nxt;
    r_r        <= r_nxt;
    val_r      <= val_nxt;
    lin_r      <= lin_nxt;
    out_data_r <= out_data_nxt;
  end

  // search probe strictly inside the window
  `LLTI_ASSERT_IMP(a_srch_window, state_r == llti_pkg::ST_SRCH_CMP, (lo_r < mid_r) && (mid_r < hi_r), "search probe outside window")
  // divider remainder stays below the divisor
  `LLTI_ASSERT_IMP(a_div_rem, state_r == llti_pkg::ST_DIV, rem_r < d_r, "divider remainder not below divisor")
  // interpolation only for a bracketed energy
  `LLTI_ASSERT_IMP(a_lerp_inside, state_r == llti_pkg::ST_LERP_MUL, inside_r && !below_r, "interpolation outside bracket")
  // a taken transfer empties the output register unless a result is loaded
  `LLTI_ASSERT_NXT(a_out_drain, out_xfer && state_r != llti_pkg::ST_DONE, !out_valid_r, "output register not emptied after transfer")

endmodule

>>> rtl/llti_ram.sv
// generic single-port-write, single-port-read ram with registered read
module llti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
